// ===== src/fcs_pkg.sv =====
// ============================================================================
// fcs_pkg - shared types and constants for the CRC-16 frame serialiser
// Sample and word types, frame byte indices, the queue head bundle and the
// byte-wise CRC-16/MODBUS update.
// ============================================================================
package fcs_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_W       = 1;
    localparam int COUNT_W     = 2;
    localparam int IDX_W       = 4;

    localparam logic [IDX_W-1:0] PAYLOAD_LAST_IDX = 4'd7;
    localparam logic [IDX_W-1:0] CRC_LO_IDX       = 4'd8;
    localparam logic [IDX_W-1:0] CRC_HI_IDX       = 4'd9;

    localparam logic [COUNT_W-1:0] QUEUE_FULL = 2'd2;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    typedef logic signed [15:0] sample_t;

    typedef struct packed {
        sample_t ch0;
        sample_t ch1;
        sample_t ch2;
        sample_t ch3;
    } word_t;

    // queue head as seen by the back end
    typedef struct packed {
        logic  valid;
        word_t word;
    } head_t;

    // one byte of reflected CRC, LSB first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int b = 0; b < 8; b++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== src/four_channel_crc16_frame_serializer_top.sv =====
// ============================================================================
// four_channel_crc16_frame_serializer_top - four-channel CRC-16 frame serialiser
// Turns each word of four 16-bit samples into a ten-byte frame with a
// trailing CRC-16/MODBUS, one byte per cycle while the output is not stalled.
// ============================================================================
// Path: in an idle block, an accepted word is written into the queue, and its
//   first frame byte is then loaded into the output register.
// Flow: bounded by the byte-wide output channel, which carries ten bytes per word;
//   a two-entry queue lets the next word be taken while a frame is sent.
// Reset: asynchronous, active low; empties the queue, drops any frame in
//   flight and re-seeds the CRC. Sample storage is not reset.
module four_channel_crc16_frame_serializer_top
(
    input  logic             clk,
    input  logic             rst_n,
    // input channel: one word of four samples
    input  logic             in_valid,
    output logic             in_stall,
    input  fcs_pkg::sample_t channel_0,
    input  fcs_pkg::sample_t channel_1,
    input  fcs_pkg::sample_t channel_2,
    input  fcs_pkg::sample_t channel_3,
    // output channel: frame bytes, ten per word
    output logic             out_valid,
    input  logic             out_stall,
    output logic [7:0]       out_byte,
    output logic             last_byte
);

    fcs_pkg::word_t in_word;
    fcs_pkg::head_t head;
    logic           pop;

    // bundle the samples in channel order
    assign in_word.ch0 = channel_0;
    assign in_word.ch1 = channel_1;
    assign in_word.ch2 = channel_2;
    assign in_word.ch3 = channel_3;

    // front: accept and queue words
    fcs_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_word  (in_word),
        .pop      (pop),
        .head     (head)
    );

    // back: serialise the head word, CRC computed on the fly; the word is
    // popped as its tenth byte enters the output register
    fcs_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .last_byte (last_byte)
    );

endmodule

// ===== src/fcs_front.sv =====
// ============================================================================
// fcs_front - input handshake and two-entry word queue
// Accepts sample words and holds each until the back end loads its last
// frame byte; stall is raised only while both entries are taken.
// ============================================================================
module fcs_front
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  fcs_pkg::word_t   in_word,
    input  logic             pop,
    output fcs_pkg::head_t   head
);

    fcs_pkg::word_t                 mem_reg [fcs_pkg::QUEUE_DEPTH];
    logic [fcs_pkg::PTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [fcs_pkg::PTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [fcs_pkg::COUNT_W-1:0]    count_reg, count_next;
    logic                           push;
    logic                           do_pop;

    assign in_stall = (count_reg == fcs_pkg::QUEUE_FULL);
    assign push     = in_valid && !in_stall;
    assign do_pop   = pop && (count_reg != '0);

    assign head.valid = (count_reg != '0);
    assign head.word  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push   ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_word;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= fcs_pkg::QUEUE_FULL)
        else $error("queue count beyond depth");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !do_pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("push without pop did not grow the queue");
`endif

endmodule

// ===== src/fcs_back.sv =====
// ============================================================================
// fcs_back - frame byte sequencer with running CRC
// Walks the head word through ten bytes, folds payload bytes into the CRC
// as they leave, and drives the registered output stage.
// ============================================================================
module fcs_back
(
    input  logic             clk,
    input  logic             rst_n,
    input  fcs_pkg::head_t   head,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [7:0]       out_byte,
    output logic             last_byte
);

    logic [fcs_pkg::IDX_W-1:0]  idx_reg;
    logic [15:0]                crc_reg;
    logic                       out_valid_reg;
    logic [7:0]                 out_byte_reg;
    logic                       out_last_reg;
    logic                       advance;
    logic                       at_last;
    logic [7:0]                 byte_sel;

    assign advance = head.valid && (!out_valid_reg || !out_stall);
    assign at_last = (idx_reg == fcs_pkg::CRC_HI_IDX);
    assign pop     = advance && at_last;

    always_comb
    begin
        unique case (idx_reg)
            4'd0:                 byte_sel = head.word.ch0[7:0];
            4'd1:                 byte_sel = head.word.ch0[15:8];
            4'd2:                 byte_sel = head.word.ch1[7:0];
            4'd3:                 byte_sel = head.word.ch1[15:8];
            4'd4:                 byte_sel = head.word.ch2[7:0];
            4'd5:                 byte_sel = head.word.ch2[15:8];
            4'd6:                 byte_sel = head.word.ch3[7:0];
            4'd7:                 byte_sel = head.word.ch3[15:8];
            fcs_pkg::CRC_LO_IDX:  byte_sel = crc_reg[7:0];
            fcs_pkg::CRC_HI_IDX:  byte_sel = crc_reg[15:8];
            default:              byte_sel = 8'h00;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            crc_reg       <= fcs_pkg::CRC_INIT;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
            if (at_last)
            begin
                idx_reg <= '0;
                crc_reg <= fcs_pkg::CRC_INIT;
            end
            else
            begin
                idx_reg <= idx_reg + 1'b1;
                if (idx_reg <= fcs_pkg::PAYLOAD_LAST_IDX)
                begin
                    crc_reg <= fcs_pkg::crc_byte(crc_reg, byte_sel);
                end
            end
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_byte_reg <= byte_sel;
            out_last_reg <= at_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign last_byte = out_last_reg;

`ifndef SYNTHESIS
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= fcs_pkg::CRC_HI_IDX)
        else $error("byte index past end of frame");

    a_crc_fresh: assert property (@(posedge clk) disable iff (!rst_n)
        (idx_reg == '0) |-> (crc_reg == fcs_pkg::CRC_INIT))
        else $error("CRC not re-seeded at frame start");

    a_last_pops: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (out_valid && last_byte && idx_reg == '0))
        else $error("frame end not marked on output");
`endif

endmodule

// ===== verif/four_channel_crc16_frame_serializer_top_test.sv =====
`timescale 1ns / 100ps
// ============================================================================
// four_channel_crc16_frame_serializer_top_test - frame serialiser testbench
// Sends words of four samples, predicts each ten-byte frame (samples low
// byte first, then CRC-16/MODBUS low byte first, last byte marked) and
// checks every output byte in order. Both channels idle and stall at random.
// ============================================================================
module four_channel_crc16_frame_serializer_top_test;

    localparam int RANDOM_WORDS = 448;
    localparam int DRAIN_CYCLES = 20;
    localparam int MODE_SPAN    = 50;   // words between idle-mode redraws
    localparam int MAX_WAIT     = 16;

    // one predicted or observed frame byte
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } frame_byte_t;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic             in_stall;
    fcs_pkg::sample_t channel_0 = '0;
    fcs_pkg::sample_t channel_1 = '0;
    fcs_pkg::sample_t channel_2 = '0;
    fcs_pkg::sample_t channel_3 = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    logic [7:0]       out_byte;
    logic             last_byte;

    fcs_pkg::word_t   pending_words[$];   // words still to be sent
    frame_byte_t      frame_bytes_due[$]; // predicted bytes not yet seen

    int          words_total    = 0;
    int          words_accepted = 0;
    int          bytes_checked  = 0;
    int          error_count    = 0;

    four_channel_crc16_frame_serializer_top dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .channel_0 (channel_0),
        .channel_1 (channel_1),
        .channel_2 (channel_2),
        .channel_3 (channel_3),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .last_byte (last_byte)
    );

    initial
    begin
        forever
        begin
            #2 clk = ~clk;
        end
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    // cycles to wait before the next word or byte; zero in a no-idle stretch
    function automatic int draw_wait(input bit no_idle);
        return no_idle ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    // Bitwise reflected CRC: feed each data bit LSB first into bit 0.
    // Same result as the byte-xor-then-shift form.
    function automatic logic [15:0] modbus_crc_add(input logic [15:0] crc,
                                                   input logic [7:0]  data);
        logic [15:0] acc;
        logic        fb;
        acc = crc;
        for (int i = 0; i < 8; i++)
        begin
            fb  = acc[0] ^ data[i];
            acc = acc >> 1;
            if (fb)
                acc = acc ^ fcs_pkg::CRC_POLY;
        end
        return acc;
    endfunction

    // Work out the ten bytes a word turns into and queue them.
    // Sign plays no part: the raw 16-bit pattern goes out as it is.
    function automatic void predict_frame(input fcs_pkg::sample_t s0,
                                          input fcs_pkg::sample_t s1,
                                          input fcs_pkg::sample_t s2,
                                          input fcs_pkg::sample_t s3);
        logic [15:0] samples[4];
        logic [15:0] crc;
        logic [7:0]  payload[8];
        frame_byte_t fb;
        samples[0] = s0;
        samples[1] = s1;
        samples[2] = s2;
        samples[3] = s3;
        crc = fcs_pkg::CRC_INIT;
        for (int ch = 0; ch < 4; ch++)
        begin
            payload[2*ch]   = samples[ch][7:0];
            payload[2*ch+1] = samples[ch][15:8];
        end
        for (int k = 0; k < 8; k++)
        begin
            crc = modbus_crc_add(crc, payload[k]);
            fb.data = payload[k];
            fb.last = 1'b0;
            frame_bytes_due.push_back(fb);
        end
        fb.data = crc[7:0];
        fb.last = 1'b0;
        frame_bytes_due.push_back(fb);
        fb.data = crc[15:8];
        fb.last = 1'b1;
        frame_bytes_due.push_back(fb);
    endfunction

    function automatic fcs_pkg::sample_t pick_sample(input bit favour_edges);
        logic [15:0] edges[6];
        edges[0] = 16'h0000;
        edges[1] = 16'hFFFF;
        edges[2] = 16'h8000;
        edges[3] = 16'h7FFF;
        edges[4] = 16'h0001;
        edges[5] = 16'hFFFE;
        if (favour_edges && $urandom_range(0, 1))
            return edges[$urandom_range(0, 5)];
        return fcs_pkg::sample_t'($urandom_range(0, 16'hFFFF));
    endfunction

    function automatic void queue_word(input logic [15:0] a, input logic [15:0] b,
                                       input logic [15:0] c, input logic [15:0] d);
        fcs_pkg::word_t w;
        w.ch0 = a;
        w.ch1 = b;
        w.ch2 = c;
        w.ch3 = d;
        pending_words.push_back(w);
        words_total++;
    endfunction

    // ------------------------------------------------------------------------
    // Driver: presents queued words, holds each one steady under stall, and
    // waits a drawn number of idle cycles after every accepted word.
    // ------------------------------------------------------------------------
    int send_gap     = 0;
    bit send_no_idle = 1'b0;

    always @(posedge clk or negedge rst_n)
    begin
        logic           take_next;
        fcs_pkg::word_t w;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            take_next = 1'b0;
            if (in_valid && !in_stall)
            begin
                // ports still hold the word that was just taken
                predict_frame(channel_0, channel_1, channel_2, channel_3);
                words_accepted++;
                if (words_accepted % MODE_SPAN == 0)
                    send_no_idle = ($urandom_range(0, 3) == 0);
                send_gap  = draw_wait(send_no_idle);
                take_next = 1'b1;
            end
            else if (!in_valid)
            begin
                take_next = 1'b1;
            end
            if (take_next)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_words.size() > 0)
                begin
                    w = pending_words.pop_front();
                    channel_0 <= w.ch0;
                    channel_1 <= w.ch1;
                    channel_2 <= w.ch2;
                    channel_3 <= w.ch3;
                    in_valid  <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: checks each accepted byte against the oldest prediction, then
    // holds stall high for a drawn number of cycles.
    // ------------------------------------------------------------------------
    int stall_left    = 0;
    bit recv_no_idle  = 1'b0;

    always @(posedge clk or negedge rst_n)
    begin
        frame_byte_t due;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (frame_bytes_due.size() == 0)
                begin
                    $display("%0t: unexpected byte: expected none, actual data %02h last %0b",
                             $time, out_byte, last_byte);
                    error_count++;
                end
                else
                begin
                    due = frame_bytes_due.pop_front();
                    if (out_byte !== due.data)
                    begin
                        $display("%0t: byte %0d out_byte: expected %02h, actual %02h",
                                 $time, bytes_checked, due.data, out_byte);
                        error_count++;
                    end
                    if (last_byte !== due.last)
                    begin
                        $display("%0t: byte %0d last_byte: expected %0b, actual %0b",
                                 $time, bytes_checked, due.last, last_byte);
                        error_count++;
                    end
                end
                bytes_checked++;
                if (bytes_checked % (MODE_SPAN * 10) == 0)
                    recv_no_idle = ($urandom_range(0, 3) == 0);
                stall_left = draw_wait(recv_no_idle);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial
    begin
        // directed: zero, all ones, sign extremes, walking and alternating bits
        queue_word(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        queue_word(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_word(16'h8000, 16'h8000, 16'h8000, 16'h8000);
        queue_word(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        queue_word(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
        queue_word(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
        queue_word(16'h0001, 16'h0100, 16'h0000, 16'hFFFF);
        queue_word(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
        queue_word(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
        queue_word(16'hFF00, 16'h00FF, 16'hFF00, 16'h00FF);
        queue_word(16'h0001, 16'h0000, 16'h0000, 16'h0000);
        queue_word(16'h0000, 16'h0000, 16'h0000, 16'h8000);
        queue_word(16'hFFFE, 16'h0001, 16'hFFFF, 16'h0000);
        queue_word(16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0);
        // random: mostly full-range, some weighted towards the extremes
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            bit edgy;
            edgy = ($urandom_range(0, 9) < 3);
            queue_word(pick_sample(edgy), pick_sample(edgy),
                       pick_sample(edgy), pick_sample(edgy));
        end

        @(posedge rst_n);
        while (words_accepted < words_total)
            @(posedge clk);
        while (frame_bytes_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d sample words (directed extremes and random) as %0d frame bytes,",
                 words_accepted, bytes_checked);
        $display("with random idle gaps and back-pressure on both channels; %0d errors.",
                 error_count);
        if (error_count == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // watchdog, several times the slowest legal run
    initial
    begin
        #2000000;
        $display("%0t: timeout with %0d words accepted, %0d bytes outstanding",
                 $time, words_accepted, frame_bytes_due.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== four_channel_crc16_frame_serializer_top.f =====
src/fcs_pkg.sv
src/fcs_front.sv
src/fcs_back.sv
src/four_channel_crc16_frame_serializer_top.sv
verif/four_channel_crc16_frame_serializer_top_test.sv
